// ----- rtl/lzwc_pkg.sv -----
package lzwc_pkg;

    // Fixed widths of the request fields and of the configuration registers.
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 12;
    localparam int WIDTH_W = 4;
    localparam int REG_W   = 9;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Code width and width limit at the start of a stream or after a clear.
    localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;
    localparam int                 START_LIMIT = 512;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_END_CODE   = 2'd0;
    localparam logic [1:0] REG_BUMP_CODE  = 2'd1;
    localparam logic [1:0] REG_CLEAR_CODE = 2'd2;
    localparam logic [1:0] REG_FIRST_FREE = 2'd3;

    // Reset values of the registers.
    localparam logic [REG_W-1:0] RST_END_CODE   = 9'd256;
    localparam logic [REG_W-1:0] RST_BUMP_CODE  = 9'd257;
    localparam logic [REG_W-1:0] RST_CLEAR_CODE = 9'd258;
    localparam logic [REG_W-1:0] RST_FIRST_FREE = 9'd259;

endpackage

// ----- rtl/lzwc_if.sv -----
// Byte request channel.
interface lzwc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lzwc_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Code request channel.
interface lzwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [lzwc_pkg::CODE_W-1:0]   code_value;
    logic [lzwc_pkg::WIDTH_W-1:0]  code_width;
    logic                          final_code;

    modport source (output valid, output code_value, output code_width, output final_code,
                    input ready);
    modport sink   (input valid, input code_value, input code_width, input final_code,
                    output ready);
endinterface

// ----- rtl/lzw_compressor_with_clear_core.sv -----
// The first byte of a stream becomes the prefix; each later byte is hashed, probed
// in the dictionary RAM (read-modify-write) until a hit, a free slot or a full pass, and
// leaves through the tail state; each code it emits passes the output register (up to 4
// per byte). A new byte is taken only in idle. Reset (synchronous, active low) starts a
// clearing pass over the RAM during which no byte is accepted; the pass repeats after
// every 255 dictionary restarts. Configuration writes are accepted at all times.
module lzw_compressor_with_clear_core #(
    parameter int CODE_BITS  = 12,
    parameter int TABLE_SIZE = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lzwc_in_if.sink                     i_in,
    lzwc_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lzwc_pkg::ADDR_W-1:0] paddr,
    input  logic [lzwc_pkg::DATA_W-1:0] pwdata,
    output logic [lzwc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int TB  = $clog2(TABLE_SIZE);
    localparam int HW  = (CODE_BITS > TB) ? CODE_BITS : TB;
    localparam int SH  = CODE_BITS - lzwc_pkg::BYTE_W;
    localparam int EPW = 8;
    localparam int EW  = EPW + TB + TB + lzwc_pkg::BYTE_W;
    localparam logic [TB:0] TS = (TB+1)'(TABLE_SIZE);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_EPRE  = 4'd3;
    localparam logic [3:0] S_ECLR  = 4'd4;
    localparam logic [3:0] S_EBUMP = 4'd5;
    localparam logic [3:0] S_TAIL  = 4'd6;
    localparam logic [3:0] S_EFL   = 4'd7;
    localparam logic [3:0] S_EEND  = 4'd8;

    // Configuration registers.
    logic [lzwc_pkg::REG_W-1:0] r_end, r_bump, r_clear, r_ff;

    // Control and item state.
    logic [3:0]                   r_state, n_state, r_ret, n_ret;
    logic [TB-1:0]                r_prefix, n_prefix;
    logic                         r_have, n_have;
    logic [TB:0]                  r_next, n_next, r_limit, n_limit;
    logic [lzwc_pkg::WIDTH_W-1:0] r_width, n_width;
    logic [EPW-1:0]               r_epoch, n_epoch;
    logic [TB-1:0]                r_idx, n_idx, r_sw, n_sw;
    logic [TB:0]                  r_cnt, n_cnt;
    logic [TB:0]                  r_step, n_step;
    logic [lzwc_pkg::BYTE_W-1:0]  r_c, n_c;
    logic                         r_last, n_last;

    // Output register.
    logic                          r_ov, n_ov;
    logic [lzwc_pkg::CODE_W-1:0]   r_ocode, n_ocode;
    logic [lzwc_pkg::WIDTH_W-1:0]  r_owidth, n_owidth;
    logic                          r_ofin, n_ofin;

    // Dictionary RAM: {epoch, code, prefix, char}.
    logic [EW-1:0] r_mem [TABLE_SIZE];
    logic [EW-1:0] r_rd, w_wd;
    logic [TB-1:0] w_ra, w_wa;
    logic          w_we;

    logic          w_acc, w_oload, w_restart, w_valid, w_match;
    logic [3:0]    w_rs_to;
    logic [HW-1:0] w_hash;
    logic [TB:0]   w_step, w_idx_ext, w_nidx;
    logic [EPW-1:0] w_rd_ep;
    logic [TB-1:0]  w_rd_code, w_rd_pre;
    logic [lzwc_pkg::BYTE_W-1:0] w_rd_chr;

    // Configuration port.
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            lzwc_pkg::REG_END_CODE:   prdata = lzwc_pkg::DATA_W'(r_end);
            lzwc_pkg::REG_BUMP_CODE:  prdata = lzwc_pkg::DATA_W'(r_bump);
            lzwc_pkg::REG_CLEAR_CODE: prdata = lzwc_pkg::DATA_W'(r_clear);
            lzwc_pkg::REG_FIRST_FREE: prdata = lzwc_pkg::DATA_W'(r_ff);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end   <= lzwc_pkg::RST_END_CODE;
            r_bump  <= lzwc_pkg::RST_BUMP_CODE;
            r_clear <= lzwc_pkg::RST_CLEAR_CODE;
            r_ff    <= lzwc_pkg::RST_FIRST_FREE;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                lzwc_pkg::REG_END_CODE:   r_end   <= pwdata[lzwc_pkg::REG_W-1:0];
                lzwc_pkg::REG_BUMP_CODE:  r_bump  <= pwdata[lzwc_pkg::REG_W-1:0];
                lzwc_pkg::REG_CLEAR_CODE: r_clear <= pwdata[lzwc_pkg::REG_W-1:0];
                lzwc_pkg::REG_FIRST_FREE: r_ff    <= pwdata[lzwc_pkg::REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshakes.
    assign i_in.ready       = (r_state == S_IDLE);
    assign w_acc            = i_in.valid && (r_state == S_IDLE);
    assign w_oload          = !r_ov || o_out.ready;
    assign o_out.valid      = r_ov;
    assign o_out.code_value = r_ocode;
    assign o_out.code_width = r_owidth;
    assign o_out.final_code = r_ofin;

    // Hash of the incoming byte against the current prefix.
    assign w_hash = (HW'(i_in.data_byte) << SH) ^ HW'(r_prefix);

    // Secondary probe step, fixed by the first slot of the probe; the index wraps around.
    assign w_step    = (w_hash[TB-1:0] == '0) ? (TB+1)'(1) : TS - {1'b0, w_hash[TB-1:0]};
    assign w_idx_ext = {1'b0, r_idx};
    assign w_nidx    = (w_idx_ext >= r_step) ? w_idx_ext - r_step : w_idx_ext + TS - r_step;

    // Fields of the entry read last cycle.
    assign {w_rd_ep, w_rd_code, w_rd_pre, w_rd_chr} = r_rd;
    assign w_valid = (w_rd_ep == r_epoch);
    assign w_match = (w_rd_pre == r_prefix) && (w_rd_chr == r_c);

    // Sequencer: probe, store, emit codes, restart the dictionary.
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_prefix = r_prefix;
        n_have   = r_have;
        n_next   = r_next;
        n_limit  = r_limit;
        n_width  = r_width;
        n_epoch  = r_epoch;
        n_idx    = r_idx;
        n_sw     = r_sw;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_c      = r_c;
        n_last   = r_last;
        n_ov     = r_ov && !o_out.ready;
        n_ocode  = r_ocode;
        n_owidth = r_owidth;
        n_ofin   = r_ofin;
        w_ra     = r_idx;
        w_we     = 1'b0;
        w_wa     = r_idx;
        w_wd     = {r_epoch, r_next[TB-1:0], r_prefix, r_c};
        w_restart = 1'b0;
        w_rs_to   = S_IDLE;

        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                w_wa = r_sw;
                w_wd = '0;
                n_sw = r_sw + 1'b1;
                if (r_sw == TB'(TABLE_SIZE - 1)) begin
                    n_state = r_ret;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_c    = i_in.data_byte;
                    n_last = i_in.last_byte;
                    if (!r_have) begin
                        n_prefix  = TB'(i_in.data_byte);
                        n_have    = 1'b1;
                        w_restart = 1'b1;
                        w_rs_to   = i_in.last_byte ? S_EFL : S_IDLE;
                    end else begin
                        n_idx   = w_hash[TB-1:0];
                        w_ra    = w_hash[TB-1:0];
                        n_step  = w_step;
                        n_cnt   = (TB+1)'(1);
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (!w_valid) begin
                    w_we    = 1'b1;
                    n_state = S_EPRE;
                end else if (w_match) begin
                    n_prefix = w_rd_code;
                    n_state  = S_TAIL;
                end else if (r_cnt == TS) begin
                    n_state = S_EPRE;
                end else begin
                    n_idx = w_nidx[TB-1:0];
                    w_ra  = w_nidx[TB-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EPRE: begin
                if (w_oload) begin
                    n_ov     = 1'b1;
                    n_ocode  = lzwc_pkg::CODE_W'(r_prefix);
                    n_owidth = r_width;
                    n_ofin   = 1'b0;
                    n_next   = r_next + 1'b1;
                    n_prefix = TB'(r_c);
                    if (n_next >= TS) begin
                        n_state = S_ECLR;
                    end else if (n_next >= r_limit) begin
                        n_state = S_EBUMP;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_ECLR: begin
                if (w_oload) begin
                    n_ov      = 1'b1;
                    n_ocode   = lzwc_pkg::CODE_W'(r_clear);
                    n_owidth  = r_width;
                    n_ofin    = 1'b0;
                    w_restart = 1'b1;
                    w_rs_to   = S_TAIL;
                end
            end
            S_EBUMP: begin
                if (w_oload) begin
                    n_ov     = 1'b1;
                    n_ocode  = lzwc_pkg::CODE_W'(r_bump);
                    n_owidth = r_width;
                    n_ofin   = 1'b0;
                    n_width  = r_width + 1'b1;
                    n_limit  = r_limit << 1;
                    n_state  = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = r_last ? S_EFL : S_IDLE;
            end
            S_EFL: begin
                if (w_oload) begin
                    n_ov     = 1'b1;
                    n_ocode  = lzwc_pkg::CODE_W'(r_prefix);
                    n_owidth = r_width;
                    n_ofin   = 1'b0;
                    n_state  = S_EEND;
                end
            end
            S_EEND: begin
                if (w_oload) begin
                    n_ov      = 1'b1;
                    n_ocode   = lzwc_pkg::CODE_W'(r_end);
                    n_owidth  = r_width;
                    n_ofin    = 1'b1;
                    n_prefix  = '0;
                    n_have    = 1'b0;
                    w_restart = 1'b1;
                    w_rs_to   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Dictionary restart: a new epoch hides all entries; a wrapped epoch
        // needs a clearing pass first.
        if (w_restart) begin
            n_next  = (TB+1)'(r_ff);
            n_width = lzwc_pkg::START_WIDTH;
            n_limit = (TB+1)'(lzwc_pkg::START_LIMIT);
            if (r_epoch == '1) begin
                n_epoch = EPW'(1);
                n_sw    = '0;
                n_ret   = w_rs_to;
                n_state = S_CLR;
            end else begin
                n_epoch = r_epoch + 1'b1;
                n_state = w_rs_to;
            end
        end
    end

    // Dictionary RAM with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_prefix <= '0;
            r_have   <= 1'b0;
            r_next   <= (TB+1)'(lzwc_pkg::RST_FIRST_FREE);
            r_limit  <= (TB+1)'(lzwc_pkg::START_LIMIT);
            r_width  <= lzwc_pkg::START_WIDTH;
            r_epoch  <= EPW'(1);
            r_sw     <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_prefix <= n_prefix;
            r_have   <= n_have;
            r_next   <= n_next;
            r_limit  <= n_limit;
            r_width  <= n_width;
            r_epoch  <= n_epoch;
            r_sw     <= n_sw;
            r_cnt    <= n_cnt;
            r_ov     <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_step   <= n_step;
        r_c      <= n_c;
        r_last   <= n_last;
        r_ocode  <= n_ocode;
        r_owidth <= n_owidth;
        r_ofin   <= n_ofin;
    end

    // The running code count stays inside the table between bytes.
    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_next < TS))
        else $error("next code reached the table size while idle");

    // Epoch zero marks cleared entries and is never the live epoch.
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_epoch != '0))
        else $error("live epoch is zero");

    // The width limit is always a power of two.
    a_limit_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_limit))
        else $error("bump limit is not a power of two");

endmodule

// ----- tb/lzw_compressor_with_clear_core_tb.sv -----
module lzw_compressor_with_clear_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL = 4096;
    localparam int HASH_SHIFT = 4;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [lzwc_pkg::BYTE_W-1:0] data_byte;
        logic                        last_byte;
    } t_byte_req;

    typedef struct {
        logic [lzwc_pkg::CODE_W-1:0]  code_value;
        logic [lzwc_pkg::WIDTH_W-1:0] code_width;
        logic                         final_code;
    } t_code_req;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [lzwc_pkg::ADDR_W-1:0] paddr;
    logic [lzwc_pkg::DATA_W-1:0] pwdata;
    logic [lzwc_pkg::DATA_W-1:0] prdata;
    logic pready;

    lzwc_in_if  byte_ch ();
    lzwc_out_if code_ch ();

    lzw_compressor_with_clear_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (code_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copies of the code registers.
    logic [lzwc_pkg::REG_W-1:0] end_code_r, bump_code_r, clear_code_r, first_free_r;

    // Dictionary and stream state of the predictor.
    bit                          dict_used [TBL];
    logic [lzwc_pkg::CODE_W-1:0] dict_cd   [TBL];
    logic [lzwc_pkg::CODE_W-1:0] dict_pre  [TBL];
    logic [lzwc_pkg::BYTE_W-1:0] dict_ch   [TBL];
    logic [lzwc_pkg::CODE_W-1:0] cur_prefix;
    logic [12:0]                 free_code;
    logic [lzwc_pkg::WIDTH_W-1:0] cur_width;
    logic [12:0]                 width_limit;
    bit                          in_stream;

    t_byte_req byte_queue[$];
    t_code_req pending_codes[$];
    int  err_cnt;
    int  codes_seen;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clear the dictionary and restore the starting width.
    function automatic void dict_restart();
        foreach (dict_used[k]) dict_used[k] = 1'b0;
        free_code   = 13'(first_free_r);
        cur_width   = lzwc_pkg::START_WIDTH;
        width_limit = 13'(lzwc_pkg::START_LIMIT);
    endfunction

    function automatic void push_code(logic [lzwc_pkg::CODE_W-1:0] cv, logic fin);
        t_code_req r;
        r.code_value = cv;
        r.code_width = cur_width;
        r.final_code = fin;
        pending_codes.push_back(r);
    endfunction

    // Expected codes for one accepted byte.
    function automatic void lzw_encode_byte(logic [lzwc_pkg::BYTE_W-1:0] c, logic last);
        logic [lzwc_pkg::CODE_W-1:0] slot, hop;
        bit hit, open_slot;
        if (!in_stream) begin
            dict_restart();
            cur_prefix = lzwc_pkg::CODE_W'(c);
            in_stream  = 1'b1;
        end else begin
            hit = 1'b0;
            open_slot = 1'b0;
            slot = (lzwc_pkg::CODE_W'(c) << HASH_SHIFT) ^ cur_prefix;
            hop  = (slot == 0) ? lzwc_pkg::CODE_W'(1) : lzwc_pkg::CODE_W'(TBL - int'(slot));
            for (int k = 0; k < TBL; k++) begin
                if (!dict_used[slot]) begin
                    open_slot = 1'b1;
                    break;
                end
                if (dict_pre[slot] == cur_prefix && dict_ch[slot] == c) begin
                    hit = 1'b1;
                    break;
                end
                slot = slot - hop;
            end
            if (hit) begin
                cur_prefix = dict_cd[slot];
            end else begin
                if (open_slot) begin
                    dict_used[slot] = 1'b1;
                    dict_cd[slot]   = free_code[lzwc_pkg::CODE_W-1:0];
                    dict_pre[slot]  = cur_prefix;
                    dict_ch[slot]   = c;
                end
                push_code(cur_prefix, 1'b0);
                free_code++;
                cur_prefix = lzwc_pkg::CODE_W'(c);
                if (free_code >= TBL) begin
                    push_code(lzwc_pkg::CODE_W'(clear_code_r), 1'b0);
                    dict_restart();
                end else if (free_code >= width_limit) begin
                    push_code(lzwc_pkg::CODE_W'(bump_code_r), 1'b0);
                    cur_width++;
                    width_limit = width_limit << 1;
                end
            end
        end
        if (last) begin
            push_code(cur_prefix, 1'b0);
            push_code(lzwc_pkg::CODE_W'(end_code_r), 1'b1);
            dict_restart();
            cur_prefix = '0;
            in_stream  = 1'b0;
        end
    endfunction

    // Request driver with random gaps; a waiting request holds until it is taken.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= '0;
            byte_ch.last_byte <= 1'b0;
            gap_left = 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                lzw_encode_byte(byte_ch.data_byte, byte_ch.last_byte);
                void'(byte_queue.pop_front());
            end
            if (!(byte_ch.valid && !byte_ch.ready)) begin
                if (gap_left > 0)
                    gap_left--;
                else if (!calm && $urandom_range(0, 11) == 0)
                    gap_left = $urandom_range(1, 10);
                if (gap_left == 0 && byte_queue.size() > 0) begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= byte_queue[0].data_byte;
                    byte_ch.last_byte <= byte_queue[0].last_byte;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Code monitor with random stalls and one long hold-off.
    int  stall_left;
    bit  long_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_ch.ready <= 1'b0;
            stall_left = 0;
            long_done  = 1'b0;
        end else begin
            if (code_ch.valid && code_ch.ready) begin
                codes_seen++;
                if (pending_codes.size() == 0) begin
                    $error("unexpected code %0d", code_ch.code_value);
                    err_cnt++;
                end else begin
                    if (code_ch.code_value !== pending_codes[0].code_value) begin
                        $error("code_value expected %0d actual %0d",
                               pending_codes[0].code_value, code_ch.code_value);
                        err_cnt++;
                    end
                    if (code_ch.code_width !== pending_codes[0].code_width) begin
                        $error("code_width expected %0d actual %0d",
                               pending_codes[0].code_width, code_ch.code_width);
                        err_cnt++;
                    end
                    if (code_ch.final_code !== pending_codes[0].final_code) begin
                        $error("final_code expected %0d actual %0d",
                               pending_codes[0].final_code, code_ch.final_code);
                        err_cnt++;
                    end
                    void'(pending_codes.pop_front());
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!long_done && codes_seen >= 40) begin
                long_done  = 1'b1;
                stall_left = 400;
            end else if (!calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 10);
            code_ch.ready <= (stall_left == 0);
        end
    end

    // Register write through the configuration port.
    task automatic reg_write(logic [1:0] idx, logic [lzwc_pkg::REG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lzwc_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= lzwc_pkg::DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lzwc_pkg::REG_END_CODE:   end_code_r   = val;
            lzwc_pkg::REG_BUMP_CODE:  bump_code_r  = val;
            lzwc_pkg::REG_CLEAR_CODE: clear_code_r = val;
            lzwc_pkg::REG_FIRST_FREE: first_free_r = val;
            default: begin
            end
        endcase
    endtask

    // Hold off until every request has gone through and the block is quiet.
    task automatic wait_idle();
        while (byte_queue.size() > 0 || byte_ch.valid || pending_codes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_byte(int b, bit last);
        t_byte_req r;
        r.data_byte = lzwc_pkg::BYTE_W'(b);
        r.last_byte = last;
        byte_queue.push_back(r);
    endtask

    // A stream of random bytes; a narrow alphabet gives many dictionary hits.
    task automatic push_stream(int len);
        int span;
        span = ($urandom_range(0, 1) == 0) ? 3 : 255;
        for (int k = 0; k < len; k++)
            push_byte($urandom_range(0, span), k == len - 1);
    endtask

    task automatic write_all(int e, int b, int c, int f);
        reg_write(lzwc_pkg::REG_END_CODE,   lzwc_pkg::REG_W'(e));
        reg_write(lzwc_pkg::REG_BUMP_CODE,  lzwc_pkg::REG_W'(b));
        reg_write(lzwc_pkg::REG_CLEAR_CODE, lzwc_pkg::REG_W'(c));
        reg_write(lzwc_pkg::REG_FIRST_FREE, lzwc_pkg::REG_W'(f));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        end_code_r = lzwc_pkg::RST_END_CODE; bump_code_r = lzwc_pkg::RST_BUMP_CODE;
        clear_code_r = lzwc_pkg::RST_CLEAR_CODE; first_free_r = lzwc_pkg::RST_FIRST_FREE;
        in_stream = 1'b0; cur_prefix = '0;
        err_cnt = 0; codes_seen = 0; calm = 1'b0;
        dict_restart();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte streams at both extremes, then repeats that hit.
        @(negedge i_clk);
        push_byte(255, 1);
        push_byte(0, 1);
        for (int k = 0; k < 10; k++) push_byte((k % 2) ? 255 : 0, 1'b0);
        push_byte(0, 1);
        for (int k = 0; k < 8; k++) push_byte(8'hA5, k == 7);
        wait_idle();

        // Extreme register values, then random well-formed streams.
        write_all(511, 256, 511, 257);
        @(negedge i_clk);
        for (int k = 0; k < 8; k++) push_stream($urandom_range(1, 20));
        wait_idle();

        // Stream from a high first code: the first new string bumps the width.
        write_all(300, 400, 299, 511);
        @(negedge i_clk);
        for (int k = 0; k < 60; k++) push_byte($urandom_range(0, 255), k == 59);
        wait_idle();

        // Random registers; streams mixed with stray single bytes.
        write_all($urandom_range(256, 511), $urandom_range(256, 511),
                  $urandom_range(256, 511), $urandom_range(257, 511));
        @(negedge i_clk);
        for (int k = 0; k < 10; k++) push_stream($urandom_range(1, 25));
        for (int k = 0; k < 30; k++) push_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
        push_byte($urandom_range(0, 255), 1);
        wait_idle();

        // Back to reset values with no random gaps or stalls.
        write_all(lzwc_pkg::RST_END_CODE, lzwc_pkg::RST_BUMP_CODE,
                  lzwc_pkg::RST_CLEAR_CODE, lzwc_pkg::RST_FIRST_FREE);
        calm = 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < 4; k++) push_stream($urandom_range(5, 20));
        wait_idle();

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
